>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check with a fixed message.
`define CHK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("port check failed");

// Check with a caller supplied message.
`define CHK_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

>>> src/mandel_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel package
// Widths, constants, shared types and the coordinate saturation function.
// ----------------------------------------------------------------------------
package mandel_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned FRAC_W   = 28;
  localparam int unsigned IN_W     = 30;
  localparam int unsigned ITER_W   = 16;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned PAL_SIZE = 200;
  localparam int unsigned PAL_W    = $clog2(PAL_SIZE);

  // Scaled products keep the integer bits of a full COORD_W square.
  localparam int unsigned PROD_W = 2 * COORD_W - FRAC_W;
  localparam int unsigned MAG_W  = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned SQ_W   = 2 * IN_W;
  localparam int unsigned RAD_W  = SQ_W + 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ITER_W-1:0]       MAX_ITER_RESET = ITER_W'(2000);
  localparam logic [RAD_W-1:0]        RAD_LIMIT      = RAD_W'(1) << (2 * FRAC_W + 1);
  localparam logic signed [MAG_W-1:0] ESC_LIMIT      = MAG_W'(4) << FRAC_W;
  localparam logic [COLOR_W-1:0]      COLOR_MAX      = '1;

  typedef enum logic [1:0] {
    CLS_ESCAPED = 2'd0,
    CLS_OUTSIDE = 2'd1,
    CLS_INSIDE  = 2'd2
  } pixel_class_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_STEP,
    BK_MULT
  } back_state_e;

  typedef struct packed {
    logic signed [IN_W-1:0] c_real;
    logic signed [IN_W-1:0] c_imag;
    logic                   outside;
  } item_t;

  typedef struct packed {
    logic [ITER_W-1:0]  escape_count;
    pixel_class_e       pixel_class;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } result_t;

  // Clamp a wide sum to the signed coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] top;
    logic signed [COORD_W-1:0] r;
    top = v[SUM_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      r = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> src/mandel_front.sv
// ----------------------------------------------------------------------------
// Mandelbrot front end
// Accepts a point, squares both parts and classes it against the radius
// precheck before handing it to the queue.
// ----------------------------------------------------------------------------
module mandel_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [mandel_pkg::IN_W-1:0]  c_real_i,
  input  logic signed [mandel_pkg::IN_W-1:0]  c_imag_i,
  output logic                                busy_o,
  input  logic                                full_i,
  output logic                                push_o,
  output mandel_pkg::item_t                   push_data_o
);

  logic                                s0_v_q;
  logic signed [mandel_pkg::IN_W-1:0]  cr0_q, ci0_q;
  logic                                s1_v_q;
  logic signed [mandel_pkg::IN_W-1:0]  cr1_q, ci1_q;
  logic [mandel_pkg::SQ_W-1:0]         sq_r_q, sq_i_q;
  logic signed [mandel_pkg::SQ_W-1:0]  sq_r, sq_i;
  logic [mandel_pkg::RAD_W-1:0]        rad;
  logic                                accept;

  // One request is in flight at a time in the front end.
  assign busy_o = s0_v_q | s1_v_q | full_i;
  assign accept = start_i & ~busy_o;

  assign sq_r = cr0_q * cr0_q;
  assign sq_i = ci0_q * ci0_q;
  assign rad  = mandel_pkg::RAD_W'(sq_r_q) + mandel_pkg::RAD_W'(sq_i_q);

  assign push_o      = s1_v_q & ~full_i;
  assign push_data_o = '{c_real: cr1_q, c_imag: ci1_q,
                         outside: (rad >= mandel_pkg::RAD_LIMIT)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      s0_v_q <= accept;
      if (s0_v_q) begin
        s1_v_q <= 1'b1;
      end else if (push_o) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cr0_q <= c_real_i;
      ci0_q <= c_imag_i;
    end
    if (s0_v_q) begin
      cr1_q  <= cr0_q;
      ci1_q  <= ci0_q;
      sq_r_q <= sq_r;
      sq_i_q <= sq_i;
    end
  end

endmodule

>>> src/mandel_queue.sv
// ----------------------------------------------------------------------------
// Mandelbrot point queue
// Short first-in first-out buffer between the front end and the iteration
// engine.
// ----------------------------------------------------------------------------
module mandel_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mandel_pkg::item_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output mandel_pkg::item_t pop_data_o
);

  mandel_pkg::item_t                 mem_q [mandel_pkg::QUEUE_DEPTH];
  logic [mandel_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [mandel_pkg::QCNT_W-1:0]     cnt_q;
  logic                              push_ok, pop_ok;

  assign full_o     = (cnt_q == mandel_pkg::QCNT_W'(mandel_pkg::QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign push_ok    = push_i & ~full_o;
  assign pop_ok     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) begin
        wr_q <= (wr_q == mandel_pkg::QPTR_W'(mandel_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_q <= (rd_q == mandel_pkg::QPTR_W'(mandel_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> src/mandel_back.sv
// ----------------------------------------------------------------------------
// Mandelbrot iteration engine
// Runs z = z^2 + c for one queued point at a time, alternating an add-and-saturate
// step and a multiplier step for each iteration, and registers the finished pixel.
// ----------------------------------------------------------------------------
module mandel_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [mandel_pkg::ITER_W-1:0]    max_iter_i,
  input  logic                             empty_i,
  input  mandel_pkg::item_t                item_i,
  output logic                             pop_o,
  output logic                             done_o,
  output mandel_pkg::result_t              result_o
);

  mandel_pkg::back_state_e              state_q, state_d;
  logic                                 done_q, chk_q;
  logic signed [mandel_pkg::IN_W-1:0]   cr_q, ci_q;
  logic signed [mandel_pkg::PROD_W-1:0] sx_q, sy_q, xy_q;
  logic signed [mandel_pkg::COORD_W-1:0] nx_q, ny_q;
  logic [mandel_pkg::ITER_W-1:0]        n_q;
  logic [mandel_pkg::PAL_W-1:0]         pal_q;
  mandel_pkg::result_t                  res_q, res_d;

  logic                                  start_run, advance, emit;
  mandel_pkg::pixel_class_e              emit_cls;
  logic signed [mandel_pkg::MAG_W-1:0]   mag;
  logic                                  esc, last;
  logic signed [mandel_pkg::SUM_W-1:0]   nx_sum, ny_sum;
  logic signed [2*mandel_pkg::COORD_W-1:0] px, py, pxy;
  logic [mandel_pkg::COLOR_W-1:0]        grey;

  // sx, sy and xy hold the scaled products of the current z.
  assign mag  = mandel_pkg::MAG_W'(sx_q) + mandel_pkg::MAG_W'(sy_q);
  assign esc  = mag > mandel_pkg::ESC_LIMIT;
  assign last = ({1'b0, n_q} + 1'b1) == {1'b0, max_iter_i};

  assign nx_sum = mandel_pkg::SUM_W'(sx_q) - mandel_pkg::SUM_W'(sy_q)
                  + mandel_pkg::SUM_W'(cr_q);
  assign ny_sum = (mandel_pkg::SUM_W'(xy_q) <<< 1) + mandel_pkg::SUM_W'(ci_q);

  assign px  = nx_q * nx_q;
  assign py  = ny_q * ny_q;
  assign pxy = nx_q * ny_q;

  assign grey = mandel_pkg::COLOR_MAX - mandel_pkg::COLOR_W'(pal_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mandel_pkg::BK_IDLE: begin
        if (!empty_i && !item_i.outside && (max_iter_i != '0)) begin
          state_d = mandel_pkg::BK_STEP;
        end
      end
      mandel_pkg::BK_STEP: begin
        if (chk_q && (esc || last)) begin
          state_d = mandel_pkg::BK_IDLE;
        end else begin
          state_d = mandel_pkg::BK_MULT;
        end
      end
      mandel_pkg::BK_MULT: state_d = mandel_pkg::BK_STEP;
      default:             state_d = mandel_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    start_run = 1'b0;
    advance   = 1'b0;
    emit      = 1'b0;
    emit_cls  = mandel_pkg::CLS_INSIDE;
    unique case (state_q)
      mandel_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (item_i.outside) begin
            emit     = 1'b1;
            emit_cls = mandel_pkg::CLS_OUTSIDE;
          end else if (max_iter_i == '0) begin
            emit = 1'b1;
          end else begin
            start_run = 1'b1;
          end
        end
      end
      mandel_pkg::BK_STEP: begin
        if (chk_q && esc) begin
          emit     = 1'b1;
          emit_cls = mandel_pkg::CLS_ESCAPED;
        end else if (chk_q && last) begin
          emit = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      mandel_pkg::BK_MULT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_d.pixel_class = emit_cls;
    case (emit_cls)
      mandel_pkg::CLS_ESCAPED: begin
        res_d.escape_count = n_q;
        res_d.red          = grey;
        res_d.green        = pal_q[0] ? grey : mandel_pkg::COLOR_MAX;
        res_d.blue         = grey;
      end
      mandel_pkg::CLS_OUTSIDE: begin
        res_d.escape_count = '0;
        res_d.red          = mandel_pkg::COLOR_MAX;
        res_d.green        = mandel_pkg::COLOR_MAX;
        res_d.blue         = mandel_pkg::COLOR_MAX;
      end
      default: begin
        res_d.escape_count = '0;
        res_d.red          = '0;
        res_d.green        = '0;
        res_d.blue         = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mandel_pkg::BK_IDLE;
      done_q  <= 1'b0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= emit;
      if (start_run) begin
        chk_q <= 1'b0;
      end else if (advance) begin
        chk_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_run) begin
      cr_q  <= item_i.c_real;
      ci_q  <= item_i.c_imag;
      sx_q  <= '0;
      sy_q  <= '0;
      xy_q  <= '0;
      n_q   <= '0;
      pal_q <= mandel_pkg::PAL_W'(1);
    end
    if (advance) begin
      nx_q <= mandel_pkg::sat_coord(nx_sum);
      ny_q <= mandel_pkg::sat_coord(ny_sum);
      // The first step of a point has no products to test yet.
      if (chk_q) begin
        n_q   <= n_q + 1'b1;
        pal_q <= (pal_q == mandel_pkg::PAL_W'(mandel_pkg::PAL_SIZE - 1)) ? '0 : pal_q + 1'b1;
      end
    end
    if (state_q == mandel_pkg::BK_MULT) begin
      sx_q <= px[2*mandel_pkg::COORD_W-1:mandel_pkg::FRAC_W];
      sy_q <= py[2*mandel_pkg::COORD_W-1:mandel_pkg::FRAC_W];
      xy_q <= pxy[2*mandel_pkg::COORD_W-1:mandel_pkg::FRAC_W];
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> src/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel
// Classes a complex point, iterates z = z^2 + c and returns its count,
// class and palette color.
// ----------------------------------------------------------------------------
//  channel   signals                               handshake
//  point     c_real_i, c_imag_i                    start / busy
//  pixel     escape_count_o, pixel_class_o, rgb    done_o strobe, one cycle
//  config    cfg_wdata_i                           cfg_we_i
//
// After a point is taken it passes the front-end registers s0 (square) and s1
// (radius compare) before it enters a two-entry queue; s1 holds while the
// queue is full. The iteration engine pops it and answers an outside or
// zero-limit point in the cycle after the pop; otherwise it alternates the
// add-and-saturate step and the multiplier step for each iteration until the
// point escapes or reaches the limit.
// Reset clears the control state and loads the iteration limit with 2000.
// The pixel port has no stall; busy rises while the front end holds a point
// or the queue is full.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [mandel_pkg::IN_W-1:0]     c_real_i,
  input  logic signed [mandel_pkg::IN_W-1:0]     c_imag_i,
  input  logic                                   cfg_we_i,
  input  logic [mandel_pkg::ITER_W-1:0]          cfg_wdata_i,
  output logic                                   done_o,
  output logic [mandel_pkg::ITER_W-1:0]          escape_count_o,
  output logic [1:0]                             pixel_class_o,
  output logic [mandel_pkg::COLOR_W-1:0]         red_o,
  output logic [mandel_pkg::COLOR_W-1:0]         green_o,
  output logic [mandel_pkg::COLOR_W-1:0]         blue_o
);

  logic [mandel_pkg::ITER_W-1:0] max_iter_q;
  logic                          push, full, pop, empty;
  mandel_pkg::item_t             push_data, pop_data;
  mandel_pkg::result_t           result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= mandel_pkg::MAX_ITER_RESET;
    end else if (cfg_we_i) begin
      max_iter_q <= cfg_wdata_i;
    end
  end

  mandel_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .c_real_i    (c_real_i),
    .c_imag_i    (c_imag_i),
    .busy_o      (busy),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mandel_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  mandel_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_iter_i (max_iter_q),
    .empty_i    (empty),
    .item_i     (pop_data),
    .pop_o      (pop),
    .done_o     (done_o),
    .result_o   (result)
  );

  assign escape_count_o = result.escape_count;
  assign pixel_class_o  = result.pixel_class;
  assign red_o          = result.red;
  assign green_o        = result.green;
  assign blue_o         = result.blue;

endmodule

>>> src/mandel_checker.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel port checker
// Watches the top level ports for consistent pixel results and request
// handling.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mandel_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                done_o,
  input logic [mandel_pkg::ITER_W-1:0]       escape_count_o,
  input logic [1:0]                          pixel_class_o,
  input logic [mandel_pkg::COLOR_W-1:0]      red_o,
  input logic [mandel_pkg::COLOR_W-1:0]      green_o,
  input logic [mandel_pkg::COLOR_W-1:0]      blue_o
);

  // A point outside the radius is white with a zero count.
  `CHK_ASSERT_MSG(a_outside_white, (done_o && pixel_class_o == mandel_pkg::CLS_OUTSIDE) |-> (escape_count_o == '0 && red_o == mandel_pkg::COLOR_MAX && green_o == mandel_pkg::COLOR_MAX && blue_o == mandel_pkg::COLOR_MAX), "outside pixel not white")

  // A point that never escaped is black with a zero count.
  `CHK_ASSERT_MSG(a_inside_black, (done_o && pixel_class_o == mandel_pkg::CLS_INSIDE) |-> (escape_count_o == '0 && red_o == '0 && green_o == '0 && blue_o == '0), "inside pixel not black")

  // Escaped pixels are grey, with green either grey or full.
  `CHK_ASSERT(a_escaped_grey, (done_o && pixel_class_o == mandel_pkg::CLS_ESCAPED) |-> (red_o == blue_o && (green_o == mandel_pkg::COLOR_MAX || green_o == red_o)))

  // A taken request occupies the front end for the following cycle.
  `CHK_ASSERT(a_busy_after_request, (start && !busy) |=> busy)

endmodule

bind mandelbrot_escape_time_pixel mandel_checker u_mandel_checker (.*);
